// File: sv/lsm_pkg.sv
package lsm_pkg;

  localparam int HISTORY_DEPTH_DEF = 256;

  localparam int STAMP_W = 64;
  localparam int LAT_W   = 32;
  localparam int STAT_W  = 64;
  localparam int NUM_LAT = 6;

  // Percentile rank fractions, as numerator over a common denominator.
  localparam int PCT_DEN = 100;
  localparam int P95_NUM = 95;
  localparam int P99_NUM = 99;

  localparam logic [2:0] STAT_COUNT = 3'd0;
  localparam logic [2:0] STAT_MIN   = 3'd1;
  localparam logic [2:0] STAT_MAX   = 3'd2;
  localparam logic [2:0] STAT_SUM   = 3'd3;
  localparam logic [2:0] STAT_SUMSQ = 3'd4;
  localparam logic [2:0] STAT_P50   = 3'd5;
  localparam logic [2:0] STAT_P95   = 3'd6;
  localparam logic [2:0] STAT_P99   = 3'd7;

  localparam logic REQ_TURN    = 1'b0;
  localparam logic REQ_SUMMARY = 1'b1;

  typedef enum logic [0:0] {
    OP_SPAN,
    OP_SATADD
  } arith_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SPAN,
    S_CORE,
    S_ACC,
    S_SEL_OUTER,
    S_SEL_LOAD,
    S_SEL_SCAN,
    S_SEL_EVAL,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic                 req_type;
    logic [STAMP_W-1:0]   vad_end_time;
    logic [STAMP_W-1:0]   stt_start_time;
    logic [STAMP_W-1:0]   stt_done_time;
    logic [STAMP_W-1:0]   llm_start_time;
    logic [STAMP_W-1:0]   first_token_time;
    logic [STAMP_W-1:0]   llm_done_time;
    logic [STAMP_W-1:0]   tts_start_time;
    logic [STAMP_W-1:0]   first_audio_time;
    logic [STAMP_W-1:0]   speaker_start_time;
  } in_beat_t;

  typedef struct packed {
    logic [LAT_W-1:0]  stt_latency;
    logic [LAT_W-1:0]  first_token_latency;
    logic [LAT_W-1:0]  llm_total_latency;
    logic [LAT_W-1:0]  first_audio_latency;
    logic [LAT_W-1:0]  e2e_latency;
    logic [LAT_W-1:0]  overhead_latency;
    logic [2:0]        stat_id;
    logic [STAT_W-1:0] stat_value;
    logic              last_result;
  } out_beat_t;

endpackage

// File: sv/lsm_arith.sv
module lsm_arith (
  input  lsm_pkg::arith_op_t  op,
  input  logic [63:0]         a,
  input  logic [63:0]         b,
  output logic [63:0]         res
);
  import lsm_pkg::*;

  logic [64:0] sum;
  logic [63:0] diff;

  assign sum  = {1'b0, a} + {1'b0, b};
  assign diff = b - a;

  // For a span, a is the start stamp and b the end stamp.
  always_comb begin
    case (op)
      OP_SPAN: begin
        if ((a == '0) || (b == '0) || (b < a)) begin
          res = '0;
        end else if (diff[63:LAT_W] != '0) begin
          res = {{(64-LAT_W){1'b0}}, {LAT_W{1'b1}}};
        end else begin
          res = diff;
        end
      end
      OP_SATADD: begin
        res = sum[64] ? '1 : sum[63:0];
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

// File: sv/lsm_ring.sv
module lsm_ring #(
  parameter int DEPTH = lsm_pkg::HISTORY_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic [lsm_pkg::LAT_W-1:0] wdata,
  input  logic [AW-1:0]            raddr,
  output logic [lsm_pkg::LAT_W-1:0] rdata_r
);
  import lsm_pkg::*;

  logic [LAT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// File: sv/latency_stats_monitor.sv
// Latency statistics monitor. A turn beat (req_type 0) carries nine tick
// stamps and returns one result beat with six stage latencies; a stamp of
// zero means unset and makes its latencies zero, and every latency
// saturates at 32 bits. Turns with a nonzero end-to-end latency update the
// saturating count, sum, sum of squares, min and max, and are written into
// a history ring of HISTORY_DEPTH entries. A summary beat (req_type 1)
// returns eight result beats, stat_id 0 through 7: count, min, max, sum,
// sum of squares, then p50, p95 and p99 of the ring. The block takes one
// request at a time and holds in_stall high until its last result beat has
// been taken. Before its result beat is offered, a turn runs its five
// spans in turn through the shared subtract/saturate unit, then forms the
// overhead and the square, then updates the sum of squares. A summary
// ranks the ring by counting, for each candidate entry, the entries below
// and at its value through the single read port of the history memory; the
// scan stops early once all three percentiles are found, then eight result
// beats follow. The history memory needs no clearing after reset, since
// only values from filled entries are ever used.
module latency_stats_monitor #(
  parameter int HISTORY_DEPTH = lsm_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lsm_pkg::in_beat_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lsm_pkg::out_beat_t   out_data
);
  import lsm_pkg::*;

  localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam int PW = CW + 7;

  state_t state_r, state_nxt;

  in_beat_t          in_r;
  logic              is_sum_r;
  logic [2:0]        step_r;
  logic [LAT_W-1:0]  lat_r [NUM_LAT];
  logic [63:0]       sq_r;

  // Running statistics.
  logic [31:0]       count_r;
  logic [63:0]       sum_r;
  logic [63:0]       sumsq_r;
  logic [LAT_W-1:0]  min_r;
  logic [LAT_W-1:0]  max_r;
  logic [AW-1:0]     wpos_r;
  logic [CW-1:0]     fill_r;

  // Rank selection.
  logic [CW-1:0]     i_r;
  logic [CW-1:0]     j_r;
  logic [CW-1:0]     lt_r;
  logic [CW-1:0]     le_r;
  logic [LAT_W-1:0]  cand_r;
  logic [2:0]        found_r;
  logic [LAT_W-1:0]  p50_r, p95_r, p99_r;
  logic [2:0]        emit_r;

  // Shared unit and memory hookups.
  arith_op_t         op;
  logic [63:0]       arith_a, arith_b, arith_res;
  logic [AW-1:0]     rd_addr;
  logic [LAT_W-1:0]  rd_data;
  logic              ring_we;

  logic              in_acc, out_acc;
  logic              e2e_hit;
  logic [CW-1:0]     last_idx;
  logic [33:0]       core;
  logic [CW-1:0]     r50;
  logic [PW-1:0]     n95, n99, lt100, le100;
  logic [2:0]        hit;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign e2e_hit  = (lat_r[4] != '0);
  assign last_idx = fill_r - CW'(1);

  assign core = {2'b00, lat_r[0]} + {2'b00, lat_r[1]} + {2'b00, lat_r[3]};

  // Rank tests: candidate holds rank r when lt <= r < le. For the scaled
  // ranks floor(n*k/100), the test is done without dividing.
  assign r50   = fill_r >> 1;
  assign n95   = PW'(fill_r) * PW'(P95_NUM);
  assign n99   = PW'(fill_r) * PW'(P99_NUM);
  assign lt100 = PW'(lt_r) * PW'(PCT_DEN);
  assign le100 = PW'(le_r) * PW'(PCT_DEN);
  assign hit[0] = (lt_r <= r50) && (r50 < le_r);
  assign hit[1] = (n95 >= lt100) && (n95 < le100);
  assign hit[2] = (n99 >= lt100) && (n99 < le100);

  lsm_arith u_arith (
    .op  (op),
    .a   (arith_a),
    .b   (arith_b),
    .res (arith_res)
  );

  lsm_ring #(
    .DEPTH (HISTORY_DEPTH),
    .AW    (AW)
  ) u_ring (
    .clk     (clk),
    .we      (ring_we),
    .waddr   (wpos_r),
    .wdata   (lat_r[4]),
    .raddr   (rd_addr),
    .rdata_r (rd_data)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data.req_type == REQ_TURN) begin
            state_nxt = S_SPAN;
          end else if (fill_r == '0) begin
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_SEL_OUTER;
          end
        end
      end
      S_SPAN: begin
        if (step_r == 3'd4) begin
          state_nxt = S_CORE;
        end
      end
      S_CORE:      state_nxt = S_ACC;
      S_ACC:       state_nxt = S_EMIT;
      S_SEL_OUTER: state_nxt = S_SEL_LOAD;
      S_SEL_LOAD:  state_nxt = S_SEL_SCAN;
      S_SEL_SCAN: begin
        if (j_r == last_idx) begin
          state_nxt = S_SEL_EVAL;
        end
      end
      S_SEL_EVAL: begin
        if ((i_r == last_idx) || ((found_r | hit) == 3'b111)) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_SEL_OUTER;
        end
      end
      S_EMIT: begin
        if (out_acc && (!is_sum_r || (emit_r == STAT_P99))) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath controls decoded from the state.
  always_comb begin
    op       = OP_SATADD;
    arith_a  = sum_r;
    arith_b  = {32'b0, lat_r[4]};
    rd_addr  = i_r[AW-1:0];
    ring_we  = 1'b0;
    in_stall = (state_r != S_IDLE);
    out_valid = (state_r == S_EMIT);
    case (state_r)
      S_SPAN: begin
        op = OP_SPAN;
        case (step_r)
          3'd0: begin
            arith_a = in_r.stt_start_time;
            arith_b = in_r.stt_done_time;
          end
          3'd1: begin
            arith_a = in_r.llm_start_time;
            arith_b = in_r.first_token_time;
          end
          3'd2: begin
            arith_a = in_r.llm_start_time;
            arith_b = in_r.llm_done_time;
          end
          3'd3: begin
            arith_a = in_r.tts_start_time;
            arith_b = in_r.first_audio_time;
          end
          default: begin
            arith_a = in_r.vad_end_time;
            arith_b = in_r.speaker_start_time;
          end
        endcase
      end
      S_ACC: begin
        arith_a = sumsq_r;
        arith_b = sq_r;
        ring_we = e2e_hit;
      end
      S_SEL_LOAD: rd_addr = '0;
      S_SEL_SCAN: rd_addr = AW'(j_r + CW'(1));
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      sum_r   <= '0;
      sumsq_r <= '0;
      min_r   <= '1;
      max_r   <= '0;
      wpos_r  <= '0;
      fill_r  <= '0;
      found_r <= '0;
      step_r  <= '0;
      emit_r  <= '0;
      is_sum_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            is_sum_r <= in_data.req_type;
            step_r   <= '0;
            emit_r   <= '0;
            found_r  <= '0;
          end
        end
        S_SPAN: step_r <= step_r + 3'd1;
        S_CORE: begin
          if (e2e_hit) begin
            sum_r <= arith_res;
          end
        end
        S_ACC: begin
          if (e2e_hit) begin
            sumsq_r <= arith_res;
            if (count_r != '1) begin
              count_r <= count_r + 32'd1;
            end
            if (lat_r[4] < min_r) begin
              min_r <= lat_r[4];
            end
            if (lat_r[4] > max_r) begin
              max_r <= lat_r[4];
            end
            wpos_r <= (wpos_r == AW'(HISTORY_DEPTH - 1)) ? '0 : wpos_r + AW'(1);
            if (fill_r != CW'(HISTORY_DEPTH)) begin
              fill_r <= fill_r + CW'(1);
            end
          end
        end
        S_SEL_EVAL: found_r <= found_r | hit;
        S_EMIT: begin
          if (out_acc) begin
            emit_r <= emit_r + 3'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          in_r  <= in_data;
          i_r   <= '0;
          p50_r <= '0;
          p95_r <= '0;
          p99_r <= '0;
        end
      end
      S_SPAN: lat_r[step_r] <= arith_res[LAT_W-1:0];
      S_CORE: begin
        lat_r[5] <= ({2'b00, lat_r[4]} > core) ?
                    LAT_W'({2'b00, lat_r[4]} - core) : '0;
        sq_r     <= 64'(lat_r[4]) * 64'(lat_r[4]);
      end
      S_SEL_LOAD: begin
        cand_r <= rd_data;
        j_r    <= '0;
        lt_r   <= '0;
        le_r   <= '0;
      end
      S_SEL_SCAN: begin
        if (rd_data < cand_r) begin
          lt_r <= lt_r + CW'(1);
        end
        if (rd_data <= cand_r) begin
          le_r <= le_r + CW'(1);
        end
        j_r <= j_r + CW'(1);
      end
      S_SEL_EVAL: begin
        if (hit[0]) begin
          p50_r <= cand_r;
        end
        if (hit[1]) begin
          p95_r <= cand_r;
        end
        if (hit[2]) begin
          p99_r <= cand_r;
        end
        i_r <= i_r + CW'(1);
      end
      default: ;
    endcase
  end

  // Result beat, built from registers that hold still while in S_EMIT.
  always_comb begin
    out_data = '0;
    if (!is_sum_r) begin
      out_data.stt_latency         = lat_r[0];
      out_data.first_token_latency = lat_r[1];
      out_data.llm_total_latency   = lat_r[2];
      out_data.first_audio_latency = lat_r[3];
      out_data.e2e_latency         = lat_r[4];
      out_data.overhead_latency    = lat_r[5];
      out_data.last_result         = 1'b1;
    end else begin
      out_data.stat_id     = emit_r;
      out_data.last_result = (emit_r == STAT_P99);
      case (emit_r)
        STAT_COUNT: out_data.stat_value = {32'b0, count_r};
        STAT_MIN:   out_data.stat_value = {32'b0, min_r};
        STAT_MAX:   out_data.stat_value = {32'b0, max_r};
        STAT_SUM:   out_data.stat_value = sum_r;
        STAT_SUMSQ: out_data.stat_value = sumsq_r;
        STAT_P50:   out_data.stat_value = {32'b0, p50_r};
        STAT_P95:   out_data.stat_value = {32'b0, p95_r};
        default:    out_data.stat_value = {32'b0, p99_r};
      endcase
    end
  end

  // The ring never claims more entries than it has.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(HISTORY_DEPTH))
    else $error("history fill count beyond depth");

  // Once a turn has been counted, min cannot exceed max.
  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> (min_r <= max_r))
    else $error("min above max after counted turns");

  // A turn result is a single beat.
  a_turn_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && !is_sum_r) |-> (emit_r == '0))
    else $error("turn produced more than one beat");

  // The ring scan never runs past the filled entries.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEL_SCAN) |-> (j_r < fill_r))
    else $error("rank scan beyond filled entries");

  // An accepted request always starts work.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != S_IDLE))
    else $error("accepted request left block idle");

endmodule
